### rtl/core/rnep_pkg.sv
`default_nettype none
package rnep_pkg;

   localparam int JOB_QUEUE_DEPTH = 2;
   localparam int DIV_BITS = 18;
   localparam logic [17:0] WHOLE_NOTE_NUM = 18'd240000;

   localparam logic [6:0] RESET_LENGTH = 7'd4;
   localparam logic [2:0] RESET_OCTAVE = 3'd6;
   localparam logic [9:0] RESET_TEMPO = 10'd63;

   localparam logic [7:0] CH_COLON = 8'd58;
   localparam logic [7:0] CH_COMMA = 8'd44;
   localparam logic [7:0] CH_EQUAL = 8'd61;
   localparam logic [7:0] CH_HASH = 8'd35;
   localparam logic [7:0] CH_DOT = 8'd46;
   localparam logic [7:0] CH_LOWER_A = 8'd97;
   localparam logic [7:0] CH_LOWER_B = 8'd98;
   localparam logic [7:0] CH_LOWER_C = 8'd99;
   localparam logic [7:0] CH_LOWER_D = 8'd100;
   localparam logic [7:0] CH_LOWER_E = 8'd101;
   localparam logic [7:0] CH_LOWER_F = 8'd102;
   localparam logic [7:0] CH_LOWER_G = 8'd103;
   localparam logic [7:0] CH_LOWER_O = 8'd111;
   localparam logic [7:0] CH_LOWER_P = 8'd112;

   localparam logic [8:0] BASE_TONE [0:11] = '{
      9'd262, 9'd277, 9'd294, 9'd311, 9'd330, 9'd349,
      9'd370, 9'd392, 9'd415, 9'd440, 9'd466, 9'd494
   };

   typedef enum logic [3:0] {
      PH_NAME   = 4'd0,
      PH_HSTART = 4'd1,
      PH_HSPACE = 4'd2,
      PH_HKEY   = 4'd3,
      PH_HSKIP  = 4'd4,
      PH_HNUM   = 4'd5,
      PH_NSTART = 4'd6,
      PH_NDUR   = 4'd7,
      PH_NLET   = 4'd8,
      PH_NBODY  = 4'd9
   } phase_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_WHOLE,
      BK_LEN,
      BK_DONE
   } back_state_type;

   typedef struct packed {
      logic [7:0] char_code;
      logic       last_char;
   } req_type;

   typedef struct packed {
      logic [14:0] tone_hz;
      logic [13:0] length_ms;
      logic        note_present;
      logic        song_end;
      logic        header_bad;
   } rsp_type;

   typedef struct packed {
      logic [14:0] tone_hz;
      logic [15:0] divisor;
      logic [9:0]  tempo;
      logic        dotted;
      logic        note_present;
      logic        song_end;
      logic        header_bad;
   } job_type;

   function automatic logic is_space(input logic [7:0] c);
      return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= 8'd48) && (c <= 8'd57);
   endfunction

   function automatic logic [7:0] to_lower(input logic [7:0] c);
      return (c >= 8'd65 && c <= 8'd90) ? c + 8'd32 : c;
   endfunction

   function automatic logic [15:0] add_digit(input logic [15:0] acc, input logic [7:0] c);
      logic [19:0] v;
      v = {acc, 3'b000} + {3'b000, acc, 1'b0} + {12'd0, c - 8'd48};
      return (v > 20'd65535) ? 16'hFFFF : v[15:0];
   endfunction

   function automatic logic [14:0] tone_of(input logic [7:0] letter,
                                           input logic [3:0] oct,
                                           input logic       sharp);
      logic [3:0]  semi;
      logic [4:0]  o;
      logic [15:0] f;
      logic        known;
      semi = 4'd0;
      known = 1'b1;
      unique case (letter)
         CH_LOWER_C: semi = 4'd0;
         CH_LOWER_D: semi = 4'd2;
         CH_LOWER_E: semi = 4'd4;
         CH_LOWER_F: semi = 4'd5;
         CH_LOWER_G: semi = 4'd7;
         CH_LOWER_A: semi = 4'd9;
         CH_LOWER_B: semi = 4'd11;
         default:    known = 1'b0;
      endcase
      o = {1'b0, oct};
      if (sharp) semi = semi + 4'd1;
      if (semi >= 4'd12) begin
         semi = semi - 4'd12;
         o = o + 5'd1;
      end
      f = {7'd0, BASE_TONE[semi]};
      if (o > 5'd4) f = f << (o - 5'd4);
      else f = f >> (5'd4 - o);
      return known ? f[14:0] : 15'd0;
   endfunction

endpackage
`default_nettype wire

### rtl/core/rtttl_note_event_parser.sv
`default_nettype none
// A character that ends a note reaches the result port after one pass of the 18-step
// divider for the note length and, before it, a second pass for the whole-note time
// when the tempo differs from the one last seen. A bare end marker skips the divider.
// Throughput: one character per cycle while the job queue has room; the back works
// off one job at a time, so notes drain only after each one's divisions are done.
// Synchronous active-high reset returns the parser to the name field.
module rtttl_note_event_parser
   import rnep_pkg::*;
#(
   parameter int JobQueueDepth = JOB_QUEUE_DEPTH
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_push,
   input  wire req_type req_data,
   output logic         req_full,
   output logic         rsp_empty,
   input  wire logic    rsp_pop,
   output rsp_type      rsp_data
);
   // The front parses every accepted character combinationally and files a job for each note or
   // song end. The back works jobs off through the shared divider. The queue between
   // them lets the parser run ahead while a division is in flight.
   logic    accept, jq_push, jq_full, jq_pop, jq_empty;
   job_type jq_in, jq_out;

   assign req_full = jq_full;
   assign accept = req_push && !jq_full;

   rnep_front u_front (
      .clock(clock), .reset(reset), .accept(accept), .req(req_data),
      .job_push(jq_push), .job(jq_in)
   );

   rnep_fifo #(.WIDTH($bits(job_type)), .DEPTH(JobQueueDepth)) u_queue (
      .clock(clock), .reset(reset), .push(jq_push), .push_data(jq_in), .full(jq_full),
      .pop(jq_pop), .pop_data(jq_out), .empty(jq_empty)
   );

   rnep_back u_back (
      .clock(clock), .reset(reset), .job_empty(jq_empty), .job(jq_out), .job_pop(jq_pop),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_data(rsp_data)
   );
endmodule
`default_nettype wire

### rtl/core/rnep_fifo.sv
`default_nettype none
module rnep_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      pop_data,
   output logic                  empty
);
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic do_push, do_pop;

   assign full = (cnt_ff == FULL_COUNT);
   assign empty = (cnt_ff == '0);
   assign do_push = push && !full;
   assign do_pop = pop && !empty;
   assign pop_data = mem_ff[rd_ff];

   always_comb begin
      wr_in = wr_ff;
      rd_in = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) wr_in = (wr_ff == LAST_SLOT) ? '0 : wr_ff + PW'(1);
      if (do_pop) rd_in = (rd_ff == LAST_SLOT) ? '0 : rd_ff + PW'(1);
      if (do_push && !do_pop) cnt_in = cnt_ff + CW'(1);
      else if (do_pop && !do_push) cnt_in = cnt_ff - CW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (do_push) mem_ff[wr_ff] <= push_data;
   end
endmodule
`default_nettype wire

### rtl/core/rnep_front.sv
`default_nettype none
module rnep_front
   import rnep_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    accept,
   input  wire req_type req,
   output logic         job_push,
   output job_type      job
);
   phase_type   phase_ff, phase_in;
   logic [6:0]  dlen_ff, dlen_in;
   logic [2:0]  doct_ff, doct_in;
   logic [9:0]  tempo_ff, tempo_in;
   logic [7:0]  key_ff, key_in;
   logic [15:0] acc_ff, acc_in;
   logic [15:0] div_ff, div_in;
   logic [7:0]  let_ff, let_in;
   logic [3:0]  oct_ff, oct_in;
   logic        sharp_ff, sharp_in, dot_ff, dot_in;
   logic        emit;
   logic [7:0]  c;

   assign c = req.char_code;

   always_comb begin
      phase_in = phase_ff;
      dlen_in = dlen_ff;
      doct_in = doct_ff;
      tempo_in = tempo_ff;
      key_in = key_ff;
      acc_in = acc_ff;
      div_in = div_ff;
      let_in = let_ff;
      oct_in = oct_ff;
      sharp_in = sharp_ff;
      dot_in = dot_ff;
      emit = 1'b0;
      unique case (phase_ff)
         PH_NAME: if (c == CH_COLON) phase_in = PH_HSTART;
         PH_HSTART, PH_HNUM: begin
            if (phase_ff == PH_HNUM && is_digit(c)) begin
               acc_in = add_digit(acc_ff, c);
            end else begin
               if (phase_ff == PH_HNUM) begin
                  // Keep a default only when it lies in its legal range.
                  if (key_ff == CH_LOWER_D && acc_ff != 16'd0 && acc_ff <= 16'd64)
                     dlen_in = acc_ff[6:0];
                  if (key_ff == CH_LOWER_O && acc_ff >= 16'd2 && acc_ff <= 16'd7)
                     doct_in = acc_ff[2:0];
                  if (key_ff == CH_LOWER_B && acc_ff >= 16'd25 && acc_ff <= 16'd900)
                     tempo_in = acc_ff[9:0];
               end
               if (phase_ff == PH_HNUM && c == CH_COMMA) phase_in = PH_HSTART;
               else if (c == CH_COLON) phase_in = PH_NSTART;
               else if (is_space(c)) phase_in = PH_HSPACE;
               else begin
                  key_in = to_lower(c);
                  phase_in = PH_HKEY;
               end
            end
         end
         PH_HSPACE: begin
            if (!is_space(c)) begin
               key_in = to_lower(c);
               phase_in = PH_HKEY;
            end
         end
         PH_HKEY: begin
            if (c == CH_EQUAL) begin
               acc_in = 16'd0;
               phase_in = PH_HNUM;
            end else if (c == CH_COMMA) phase_in = PH_HSTART;
            else if (c == CH_COLON) phase_in = PH_NSTART;
            else phase_in = PH_HSKIP;
         end
         PH_HSKIP: begin
            if (c == CH_COMMA) phase_in = PH_HSTART;
            else if (c == CH_COLON) phase_in = PH_NSTART;
         end
         PH_NSTART, PH_NDUR: begin
            if (is_digit(c)) begin
               acc_in = add_digit((phase_ff == PH_NSTART) ? 16'd0 : acc_ff, c);
               phase_in = PH_NDUR;
            end else if (!(phase_ff == PH_NSTART && is_space(c))) begin
               // The character after a duration is always taken as the letter.
               div_in = (phase_ff == PH_NDUR && acc_ff != 16'd0) ? acc_ff : {9'd0, dlen_ff};
               let_in = to_lower(c);
               sharp_in = 1'b0;
               dot_in = 1'b0;
               oct_in = {1'b0, doct_ff};
               phase_in = PH_NLET;
            end
         end
         PH_NLET, PH_NBODY: begin
            if (phase_ff == PH_NLET && c == CH_HASH) begin
               sharp_in = 1'b1;
               phase_in = PH_NBODY;
            end else begin
               phase_in = PH_NBODY;
               if (c == CH_COMMA) begin
                  emit = 1'b1;
                  phase_in = PH_NSTART;
               end else if (c == CH_DOT) dot_in = 1'b1;
               else if (is_digit(c)) oct_in = 4'(c - 8'd48);
            end
         end
         default: phase_in = PH_NAME;
      endcase

      job.tone_hz = (let_in == CH_LOWER_P) ? 15'd0 : tone_of(let_in, oct_in, sharp_in);
      job.divisor = (div_in == 16'd0) ? 16'd1 : div_in;
      job.tempo = tempo_in;
      job.dotted = dot_in;
      job.note_present = 1'b1;
      job.song_end = req.last_char;
      job.header_bad = 1'b0;
      if (!emit && req.last_char) begin
         if (phase_in == PH_HSTART || phase_in == PH_HSPACE || phase_in == PH_HKEY ||
             phase_in == PH_HSKIP || phase_in == PH_HNUM || phase_in == PH_NAME) begin
            job.note_present = 1'b0;
            job.header_bad = 1'b1;
         end else if (!(phase_in == PH_NLET || phase_in == PH_NBODY)) begin
            job.note_present = 1'b0;
         end
      end
      if (!job.note_present) job.tone_hz = 15'd0;
      job_push = accept && (emit || req.last_char);
   end

   always_ff @(posedge clock) begin
      if (reset || (accept && req.last_char)) begin
         phase_ff <= PH_NAME;
         dlen_ff <= RESET_LENGTH;
         doct_ff <= RESET_OCTAVE;
         tempo_ff <= RESET_TEMPO;
         key_ff <= 8'd0;
         acc_ff <= 16'd0;
         div_ff <= 16'd0;
         let_ff <= 8'd0;
         oct_ff <= 4'd0;
         sharp_ff <= 1'b0;
         dot_ff <= 1'b0;
      end else if (accept) begin
         phase_ff <= phase_in;
         dlen_ff <= dlen_in;
         doct_ff <= doct_in;
         tempo_ff <= tempo_in;
         key_ff <= key_in;
         acc_ff <= acc_in;
         div_ff <= div_in;
         let_ff <= let_in;
         oct_ff <= oct_in;
         sharp_ff <= sharp_in;
         dot_ff <= dot_in;
      end
   end
endmodule
`default_nettype wire

### rtl/core/rnep_div.sv
`default_nettype none
module rnep_div
   import rnep_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire logic [DIV_BITS-1:0] dividend,
   input  wire logic [15:0]         divisor,
   output logic                     done,
   output logic [DIV_BITS-1:0]      quotient
);
   localparam int CNT_W = $clog2(DIV_BITS + 1);

   logic [DIV_BITS-1:0] q_ff, q_in;
   logic [16:0]         rem_ff, rem_in, rem_sh;
   logic [15:0]         dvs_ff;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic                done_ff, done_in;

   assign quotient = q_ff;
   assign done = done_ff;

   always_comb begin
      rem_sh = {rem_ff[15:0], q_ff[DIV_BITS-1]};
      q_in = q_ff;
      rem_in = rem_ff;
      cnt_in = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         q_in = dividend;
         rem_in = 17'd0;
         cnt_in = CNT_W'(DIV_BITS);
      end else if (cnt_ff != '0) begin
         // One quotient bit per cycle, restoring form.
         if (rem_sh >= {1'b0, dvs_ff}) begin
            rem_in = rem_sh - {1'b0, dvs_ff};
            q_in = {q_ff[DIV_BITS-2:0], 1'b1};
         end else begin
            rem_in = rem_sh;
            q_in = {q_ff[DIV_BITS-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CNT_W'(1);
         done_in = (cnt_ff == CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         done_ff <= done_in;
      end
      q_ff <= q_in;
      rem_ff <= rem_in;
      if (start) dvs_ff <= divisor;
   end
endmodule
`default_nettype wire

### rtl/core/rnep_back.sv
`default_nettype none
module rnep_back
   import rnep_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    job_empty,
   input  wire job_type job,
   output logic         job_pop,
   output logic         rsp_empty,
   input  wire logic    rsp_pop,
   output rsp_type      rsp_data
);
   back_state_type      st_ff, st_in;
   job_type             job_ff;
   logic [13:0]         whole_ff, len_ff;
   logic [9:0]          ctempo_ff;
   logic                cvalid_ff, out_valid_ff, out_load;
   rsp_type             out_ff;
   logic                dstart, ddone;
   logic [DIV_BITS-1:0] ddvd, dq;
   logic [15:0]         ddvs;
   logic [14:0]         len_sum;

   rnep_div u_div (
      .clock(clock), .reset(reset), .start(dstart), .dividend(ddvd),
      .divisor(ddvs), .done(ddone), .quotient(dq)
   );

   assign len_sum = {1'b0, dq[13:0]} + {2'b00, dq[13:1]};
   assign rsp_empty = !out_valid_ff;
   assign rsp_data = out_ff;

   always_comb begin
      st_in = st_ff;
      job_pop = 1'b0;
      dstart = 1'b0;
      ddvd = WHOLE_NOTE_NUM;
      ddvs = {6'd0, job.tempo};
      out_load = 1'b0;
      unique case (st_ff)
         BK_IDLE: begin
            if (!job_empty) begin
               job_pop = 1'b1;
               if (!job.note_present) st_in = BK_DONE;
               else if (cvalid_ff && ctempo_ff == job.tempo) begin
                  dstart = 1'b1;
                  ddvd = {4'd0, whole_ff};
                  ddvs = job.divisor;
                  st_in = BK_LEN;
               end else begin
                  dstart = 1'b1;
                  st_in = BK_WHOLE;
               end
            end
         end
         BK_WHOLE: begin
            if (ddone) begin
               dstart = 1'b1;
               ddvd = {4'd0, dq[13:0]};
               ddvs = job_ff.divisor;
               st_in = BK_LEN;
            end
         end
         BK_LEN: if (ddone) st_in = BK_DONE;
         BK_DONE: begin
            if (!out_valid_ff || rsp_pop) begin
               out_load = 1'b1;
               st_in = BK_IDLE;
            end
         end
         default: st_in = BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= BK_IDLE;
         cvalid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         if (st_ff == BK_WHOLE && ddone) cvalid_ff <= 1'b1;
         if (out_load) out_valid_ff <= 1'b1;
         else if (rsp_pop) out_valid_ff <= 1'b0;
      end
      if (job_pop) begin
         job_ff <= job;
         len_ff <= 14'd0;
      end
      if (st_ff == BK_WHOLE && ddone) begin
         whole_ff <= dq[13:0];
         ctempo_ff <= job_ff.tempo;
      end
      if (st_ff == BK_LEN && ddone) len_ff <= job_ff.dotted ? len_sum[13:0] : dq[13:0];
      if (out_load) begin
         out_ff.tone_hz <= job_ff.tone_hz;
         out_ff.length_ms <= len_ff;
         out_ff.note_present <= job_ff.note_present;
         out_ff.song_end <= job_ff.song_end;
         out_ff.header_bad <= job_ff.header_bad;
      end
   end
endmodule
`default_nettype wire

### tb/rtttl_note_event_parser_tb.sv
`timescale 1ns / 1ps
module rtttl_note_event_parser_tb;
   import rnep_pkg::*;

   // The limit covers every character ending a note, the longest receiver stall and
   // sender gap, many times over.
   localparam int CYCLE_LIMIT = 900000;
   localparam int DRAIN_CYCLES = 60;

   logic    clock;
   logic    reset;
   logic    req_push;
   req_type req_data;
   logic    req_full;
   logic    rsp_empty;
   logic    rsp_pop;
   rsp_type rsp_data;

   rtttl_note_event_parser u_dut (
      .clock(clock),
      .reset(reset),
      .req_push(req_push),
      .req_data(req_data),
      .req_full(req_full),
      .rsp_empty(rsp_empty),
      .rsp_pop(rsp_pop),
      .rsp_data(rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Predictor state: a copy of everything the parser remembers between words.
   phase_type   p_phase;
   logic [6:0]  p_def_len;
   logic [2:0]  p_def_oct;
   logic [9:0]  p_tempo;
   logic [13:0] p_whole_ms;
   logic [7:0]  p_key;
   logic [15:0] p_accum;
   logic [15:0] p_divisor;
   logic [7:0]  p_letter;
   logic [3:0]  p_octave;
   logic        p_sharp;
   logic        p_dotted;

   rsp_type     expected_notes[$];
   int          error_count;
   longint      cycle_count;

   function automatic logic white(input logic [7:0] c);
      return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
   endfunction

   function automatic logic numeral(input logic [7:0] c);
      return c >= 8'd48 && c <= 8'd57;
   endfunction

   function automatic logic [7:0] fold(input logic [7:0] c);
      return (c >= 8'd65 && c <= 8'd90) ? c + 8'd32 : c;
   endfunction

   function automatic void clear_song();
      p_phase = PH_NAME;
      p_def_len = RESET_LENGTH;
      p_def_oct = RESET_OCTAVE;
      p_tempo = RESET_TEMPO;
      p_whole_ms = '0;
      p_key = '0;
      p_accum = '0;
      p_divisor = '0;
      p_letter = '0;
      p_octave = '0;
      p_sharp = 1'b0;
      p_dotted = 1'b0;
   endfunction

   function automatic void push_digit(input logic [7:0] c);
      int unsigned v;
      v = p_accum * 10 + (c - 8'd48);
      p_accum = (v > 65535) ? 16'hFFFF : v[15:0];
   endfunction

   function automatic void open_notes();
      p_whole_ms = 14'(240000 / ((p_tempo != 0) ? p_tempo : 10'd63));
      p_phase = PH_NSTART;
   endfunction

   function automatic void header_char(input logic [7:0] c);
      if (c == CH_COLON) open_notes();
      else if (white(c)) p_phase = PH_HSPACE;
      else begin
         p_key = fold(c);
         p_phase = PH_HKEY;
      end
   endfunction

   function automatic void start_note(input logic [7:0] c);
      p_letter = fold(c);
      p_sharp = 1'b0;
      p_dotted = 1'b0;
      p_octave = {1'b0, p_def_oct};
      p_phase = PH_NLET;
   endfunction

   // Frequency in Hz of the pending note, worked out by repeated doubling and halving.
   function automatic logic [14:0] pitch_hz();
      int semi;
      int oct;
      int f;
      oct = p_octave;
      case (p_letter)
         CH_LOWER_C: semi = 0;
         CH_LOWER_D: semi = 2;
         CH_LOWER_E: semi = 4;
         CH_LOWER_F: semi = 5;
         CH_LOWER_G: semi = 7;
         CH_LOWER_A: semi = 9;
         CH_LOWER_B: semi = 11;
         default: return 15'd0;
      endcase
      if (p_sharp) semi++;
      if (semi >= 12) begin
         semi -= 12;
         oct++;
      end
      case (semi)
         0: f = 262;   1: f = 277;   2: f = 294;   3: f = 311;
         4: f = 330;   5: f = 349;   6: f = 370;   7: f = 392;
         8: f = 415;   9: f = 440;  10: f = 466;  default: f = 494;
      endcase
      while (oct > 4) begin f *= 2; oct--; end
      while (oct < 4) begin f /= 2; oct++; end
      return f[14:0];
   endfunction

   function automatic rsp_type note_word(input logic ends);
      rsp_type r;
      int unsigned d;
      int unsigned len;
      d = (p_divisor != 0) ? p_divisor : 1;
      len = p_whole_ms / d;
      if (p_dotted) len += len / 2;
      r.tone_hz = (p_letter == CH_LOWER_P) ? 15'd0 : pitch_hz();
      r.length_ms = len[13:0];
      r.note_present = 1'b1;
      r.song_end = ends;
      r.header_bad = 1'b0;
      return r;
   endfunction

   // Advances the predicted parser by one character; returns 1 and the word if one is due.
   function automatic logic parse_char(input req_type w, output rsp_type r);
      logic [7:0] c;
      logic emitted;
      c = w.char_code;
      emitted = 1'b0;
      r = '0;
      case (p_phase)
         PH_NAME: if (c == CH_COLON) p_phase = PH_HSTART;
         PH_HSTART: header_char(c);
         PH_HSPACE: if (!white(c)) begin
            p_key = fold(c);
            p_phase = PH_HKEY;
         end
         PH_HKEY: begin
            if (c == CH_EQUAL) begin
               p_accum = '0;
               p_phase = PH_HNUM;
            end else if (c == CH_COMMA) p_phase = PH_HSTART;
            else if (c == CH_COLON) open_notes();
            else p_phase = PH_HSKIP;
         end
         PH_HSKIP: begin
            if (c == CH_COMMA) p_phase = PH_HSTART;
            else if (c == CH_COLON) open_notes();
         end
         PH_HNUM: begin
            if (numeral(c)) push_digit(c);
            else begin
               // Out-of-range values leave the previous default in place.
               if (p_key == CH_LOWER_D && p_accum > 0 && p_accum <= 64)
                  p_def_len = p_accum[6:0];
               if (p_key == CH_LOWER_O && p_accum >= 2 && p_accum <= 7)
                  p_def_oct = p_accum[2:0];
               if (p_key == CH_LOWER_B && p_accum >= 25 && p_accum <= 900)
                  p_tempo = p_accum[9:0];
               if (c == CH_COMMA) p_phase = PH_HSTART;
               else header_char(c);
            end
         end
         PH_NSTART: begin
            if (white(c)) begin
            end else if (numeral(c)) begin
               p_accum = '0;
               push_digit(c);
               p_phase = PH_NDUR;
            end else begin
               p_divisor = {9'd0, p_def_len};
               start_note(c);
            end
         end
         PH_NDUR: begin
            if (numeral(c)) push_digit(c);
            else begin
               // Whatever follows the digits is taken as the letter, even a comma.
               p_divisor = (p_accum != 0) ? p_accum : {9'd0, p_def_len};
               start_note(c);
            end
         end
         PH_NLET, PH_NBODY: begin
            if (p_phase == PH_NLET && c == CH_HASH) begin
               p_sharp = 1'b1;
               p_phase = PH_NBODY;
            end else begin
               p_phase = PH_NBODY;
               if (c == CH_COMMA) begin
                  r = note_word(w.last_char);
                  emitted = 1'b1;
                  p_phase = PH_NSTART;
               end else if (c == CH_DOT) p_dotted = 1'b1;
               else if (numeral(c)) p_octave = 4'(c - 8'd48);
            end
         end
         default: p_phase = PH_NAME;
      endcase
      if (w.last_char) begin
         if (!emitted) begin
            if (p_phase < PH_NSTART) r = '{15'd0, 14'd0, 1'b0, 1'b1, 1'b1};
            else if (p_phase == PH_NLET || p_phase == PH_NBODY) r = note_word(1'b1);
            else r = '{15'd0, 14'd0, 1'b0, 1'b1, 1'b0};
            emitted = 1'b1;
         end
         clear_song();
      end
      return emitted;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      error_count++;
      $display("mismatch %s: got %0d expected %0d", what, got, want);
   endtask

   // Receiver: stalls on a repeating pattern whose mask changes now and then.
   logic [15:0] stall_mask;
   int          stall_phase;

   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
         stall_phase <= 0;
      end else begin
         rsp_type want;
         if (rsp_pop && !rsp_empty) begin
            if (expected_notes.size() == 0) begin
               report_mismatch("unexpected word", rsp_data.tone_hz, 0);
            end else begin
               want = expected_notes.pop_front();
               if (rsp_data.tone_hz !== want.tone_hz)
                  report_mismatch("tone_hz", rsp_data.tone_hz, want.tone_hz);
               if (rsp_data.length_ms !== want.length_ms)
                  report_mismatch("length_ms", rsp_data.length_ms, want.length_ms);
               if (rsp_data.note_present !== want.note_present)
                  report_mismatch("note_present", rsp_data.note_present, want.note_present);
               if (rsp_data.song_end !== want.song_end)
                  report_mismatch("song_end", rsp_data.song_end, want.song_end);
               if (rsp_data.header_bad !== want.header_bad)
                  report_mismatch("header_bad", rsp_data.header_bad, want.header_bad);
            end
         end
         stall_phase <= (stall_phase + 1) % 16;
         if (stall_phase == 15 && $urandom_range(0, 3) == 0) stall_mask <= $urandom;
         rsp_pop <= stall_mask[stall_phase];
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // Directed rows: the word and, where it is obvious, the result it must give.
   typedef struct {
      logic [7:0] c;
      logic       last;
      logic       typed;
      rsp_type    want;
   } stim_row;

   stim_row directed[$];
   string   song_text;

   task automatic add_text(input string s, input logic last_at_end);
      for (int i = 0; i < s.len(); i++)
         directed.push_back('{s[i], last_at_end && i == s.len() - 1, 1'b0, '0});
   endtask

   // One word through the handshake; the predictor runs when it is accepted.
   task automatic send_char(input logic [7:0] c, input logic last,
                            input logic typed, input rsp_type want);
      rsp_type r;
      req_push <= 1'b1;
      req_data <= '{c, last};
      @(posedge clock);
      while (req_full) @(posedge clock);
      if (parse_char('{c, last}, r)) begin
         if (typed && r !== want) report_mismatch("directed row predictor", r, want);
         expected_notes.push_back(r);
      end
   endtask

   task automatic send_gap();
      req_push <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clock);
   endtask

   // Builds a random song: mostly well formed, with noise and broken pieces.
   task automatic random_song(output string s);
      string letters;
      int    n;
      letters = "cdefgabpCDEFGABPhx";
      s = "";
      if ($urandom_range(0, 9) == 0) begin
         n = $urandom_range(1, 12);
         for (int i = 0; i < n; i++) s = {s, string'(8'($urandom))};
         return;
      end
      n = $urandom_range(0, 3);
      for (int i = 0; i < n; i++) s = {s, "N"};
      s = {s, ":"};
      if ($urandom_range(0, 1)) s = {s, $sformatf("d=%0d,", $urandom_range(0, 70))};
      if ($urandom_range(0, 1)) s = {s, $sformatf(" o=%0d,", $urandom_range(0, 9))};
      if ($urandom_range(0, 1)) s = {s, $sformatf("B=%0d", $urandom_range(10, 1000))};
      if ($urandom_range(0, 7) == 0) s = {s, ",x:"};
      else s = {s, ":"};
      n = $urandom_range(1, 6);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 3) == 0) s = {s, " "};
         if ($urandom_range(0, 1)) s = {s, $sformatf("%0d", 1 << $urandom_range(0, 6))};
         s = {s, string'(letters[$urandom_range(0, letters.len() - 1)])};
         if ($urandom_range(0, 2) == 0) s = {s, "#"};
         if ($urandom_range(0, 2) == 0) s = {s, "."};
         if ($urandom_range(0, 1)) s = {s, string'(8'd48 + 8'($urandom_range(0, 9)))};
         if ($urandom_range(0, 5) == 0) s = {s, string'(8'($urandom))};
         if (i != n - 1 || $urandom_range(0, 2) == 0) s = {s, ","};
      end
   endtask

   initial begin
      int sent;
      int burst;
      error_count = 0;
      cycle_count = 0;
      stall_mask = 16'hFFFF;
      reset = 1'b1;
      req_push = 1'b0;
      req_data = '0;
      clear_song();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Header end: the text stops before the note section.
      directed.push_back('{8'd0, 1'b1, 1'b1, '{15'd0, 14'd0, 1'b0, 1'b1, 1'b1}});
      directed.push_back('{8'd255, 1'b1, 1'b1, '{15'd0, 14'd0, 1'b0, 1'b1, 1'b1}});
      // A full song; the comma as last word carries song_end on its note.
      add_text("x:d=64,o=7,b=900:32A#7.,P,", 1'b1);
      // Space then colon in the defaults, overflowed divisor, zero divisor.
      add_text(": :,:99999c,0e,", 1'b0);
      // Empty trailing note after bare digits gives a plain end marker.
      directed.push_back('{8'd52, 1'b1, 1'b1, '{15'd0, 14'd0, 1'b0, 1'b1, 1'b0}});
      for (int i = 0; i < directed.size(); i++)
         send_char(directed[i].c, directed[i].last, directed[i].typed, directed[i].want);
      req_push <= 1'b0;

      // Hold off until every outstanding note has drained.
      while (expected_notes.size() != 0) @(posedge clock);

      sent = 0;
      while (sent < 800) begin
         random_song(song_text);
         burst = $urandom_range(1, 20);
         for (int i = 0; i < song_text.len(); i++) begin
            send_char(song_text[i], i == song_text.len() - 1, 1'b0, '0);
            sent++;
            if (--burst == 0) begin
               send_gap();
               burst = $urandom_range(1, 20);
            end
         end
         if (sent > 400 && sent < 430) stall_mask = 16'hFFFF;
      end
      req_push <= 1'b0;

      stall_mask = 16'hFFFF;
      while (expected_notes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
